FILE: rtl/core/cdwc_pkg.sv
// Shared constants, codes and types of the decayed weighted correction table.
// Used by every module of the block but cdwc_ram; no dependencies.
package cdwc_pkg;

  localparam int DEF_N_ROWS = 16;
  localparam int DEF_N_COLS = 16;

  localparam int CONF_LOW    = 3;
  localparam int CONF_MEDIUM = 10;
  localparam int CONF_HIGH   = 30;

  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CELL_W     = 128;
  localparam int DIV_STEPS  = 48;

  localparam logic [15:0] ONE_Q14 = 16'd16384;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] REG_MIN_SMP      = 3'd0;
  localparam logic [2:0] REG_DECAY_RATE   = 3'd1;
  localparam logic [2:0] REG_CLAMP_ENABLE = 3'd2;
  localparam logic [2:0] REG_CLAMP_LIMIT  = 3'd3;
  localparam logic [2:0] REG_VE_LOW       = 3'd4;
  localparam logic [2:0] REG_VE_HIGH      = 3'd5;

  // controller states, also the datapath step codes
  localparam logic [4:0] ST_CLR  = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_RD   = 5'd2;
  localparam logic [4:0] ST_CLRW = 5'd3;
  localparam logic [4:0] ST_D1   = 5'd4;
  localparam logic [4:0] ST_D2   = 5'd5;
  localparam logic [4:0] ST_D3   = 5'd6;
  localparam logic [4:0] ST_D4   = 5'd7;
  localparam logic [4:0] ST_D5   = 5'd8;
  localparam logic [4:0] ST_D6   = 5'd9;
  localparam logic [4:0] ST_S1   = 5'd10;
  localparam logic [4:0] ST_S2   = 5'd11;
  localparam logic [4:0] ST_S3   = 5'd12;
  localparam logic [4:0] ST_EW   = 5'd13;
  localparam logic [4:0] ST_A1   = 5'd14;
  localparam logic [4:0] ST_A2   = 5'd15;
  localparam logic [4:0] ST_DIVI = 5'd16;
  localparam logic [4:0] ST_DIV  = 5'd17;
  localparam logic [4:0] ST_R1   = 5'd18;
  localparam logic [4:0] ST_R2   = 5'd19;
  localparam logic [4:0] ST_R3   = 5'd20;
  localparam logic [4:0] ST_R4   = 5'd21;

  typedef struct packed {
    logic [4:0] step;
    logic       accept;
    logic       load_out;
  } cdwc_cmd_t;

  typedef struct packed {
    logic       addr_ok;
    logic [1:0] op;
    logic       cnt_zero;
    logic       newer;
    logic       sweep_last;
    logic       div_last;
  } cdwc_stat_t;

  // 2^(-i/16) in Q.16
  function automatic logic [16:0] pow2_tab(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/cdwc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cdwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/core/cdwc_dp.sv
// Datapath: cell store, decay factor pipeline steps, divider, report logic.
// Depends on cdwc_pkg and cdwc_ram; sequenced by cdwc_ctrl.
module cdwc_dp #(
  parameter int N_ROWS = cdwc_pkg::DEF_N_ROWS,
  parameter int N_COLS = cdwc_pkg::DEF_N_COLS,
  localparam int CELLS = N_ROWS * N_COLS,
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cdwc_pkg::cdwc_cmd_t                  cmd_i,
  output cdwc_pkg::cdwc_stat_t                 stat_o,
  input  logic [cdwc_pkg::IN_DATA_W-1:0]       in_data_i,
  input  logic [cdwc_pkg::IN_USER_W-1:0]       in_user_i,
  input  logic                                 cfg_we_i,
  input  logic [cdwc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cdwc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic [cdwc_pkg::OUT_DATA_W-1:0]      out_data_o
);
  import cdwc_pkg::*;

  logic [15:0] min_smp_q, decay_rate_q, ve_low_q, ve_high_q;
  logic        clamp_enable_q;
  logic [14:0] clamp_limit_q;

  logic [3:0]  in_row, in_col;
  logic [AW-1:0] in_addr;
  logic        in_ok;

  logic [1:0]  op_q;
  logic        addr_ok_q;
  logic [AW-1:0] addr_q;
  logic [15:0] corr_q, w_q, pve_q;
  logic [31:0] stamp_q;
  logic        known_q;

  logic [31:0] wsum_q, newest_q;
  logic [47:0] wt_q;
  logic [15:0] cnt_q;
  logic        newer_q;

  logic [47:0] p_q;
  logic        big_q;
  logic [38:0] m_q;
  logic [51:0] r_prod_q;
  logic [20:0] y_q;
  logic [4:0]  n_q;
  logic [16:0] tj_q;
  logic [23:0] ip_q;
  logic [16:0] f_q;
  logic [48:0] pw_q;
  logic [40:0] plo_q, phi_q;
  logic [15:0] ew_q;
  logic [31:0] ewc_q;
  logic [32:0] rem_q;
  logic [47:0] quo_q;
  logic [15:0] raw_q, mean_q;
  logic        clamped_q;
  logic [31:0] pp_q;

  logic [AW-1:0] swp_q;
  logic [5:0]    div_q;

  logic [15:0] o_cnt_q, o_mean_q, o_raw_q, o_prop_q;
  logic        o_clamped_q, o_has_q;
  logic [1:0]  o_level_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;
  logic [31:0] rd_wsum, rd_newest;
  logic [47:0] rd_wt;
  logic [15:0] rd_cnt;

  logic [31:0] age;
  logic [27:0] dx;
  logic [21:0] dq0;
  logic [28:0] drem;
  logic [16:0] tdiff, dv;
  logic [65:0] ts;
  logic [32:0] ws_new, rem_n;
  logic [48:0] wt_new, qq;
  logic        sum_ok;
  logic [15:0] cnt_new;
  logic        rup;
  logic [16:0] clo, chi;
  logic [15:0] cmean;
  logic [29:0] vlo, vhi;
  logic [31:0] plim;
  logic        pup;
  logic [18:0] pq;
  logic        has;
  logic [1:0]  level;

  assign in_row  = in_data_i[3:0];
  assign in_col  = in_data_i[7:4];
  assign in_ok   = (32'(in_row) < N_ROWS) && (32'(in_col) < N_COLS);
  assign in_addr = AW'(32'(in_row) * N_COLS + 32'(in_col));

  assign rd_wsum   = ram_rdata[31:0];
  assign rd_wt     = ram_rdata[79:32];
  assign rd_cnt    = ram_rdata[95:80];
  assign rd_newest = ram_rdata[127:96];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_smp_q      <= 16'd3;
      decay_rate_q   <= '0;
      clamp_enable_q <= 1'b0;
      clamp_limit_q  <= '0;
      ve_low_q       <= '0;
      ve_high_q      <= 16'hFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_SMP:      min_smp_q      <= cfg_data_i;
        REG_DECAY_RATE:   decay_rate_q   <= cfg_data_i;
        REG_CLAMP_ENABLE: clamp_enable_q <= cfg_data_i[0];
        REG_CLAMP_LIMIT:  clamp_limit_q  <= cfg_data_i[14:0];
        REG_VE_LOW:       ve_low_q       <= cfg_data_i;
        REG_VE_HIGH:      ve_high_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swp_q <= '0;
      div_q <= '0;
    end else begin
      if (cmd_i.step == ST_CLR) begin
        swp_q <= swp_q + 1'b1;
      end
      if (cmd_i.step == ST_DIVI) begin
        div_q <= '0;
      end else if (cmd_i.step == ST_DIV) begin
        div_q <= div_q + 6'd1;
      end
    end
  end

  assign stat_o.addr_ok    = addr_ok_q;
  assign stat_o.op         = op_q;
  assign stat_o.cnt_zero   = (rd_cnt == 16'd0);
  assign stat_o.newer      = newer_q;
  assign stat_o.sweep_last = (swp_q == AW'(CELLS - 1));
  assign stat_o.div_last   = (div_q == 6'(DIV_STEPS - 1));

  always_comb begin
    ws_new  = 33'(wsum_q) + 33'(ew_q);
    wt_new  = 49'(wt_q) + 49'(ewc_q);
    sum_ok  = !ws_new[32] && !wt_new[48];
    cnt_new = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    priority case (cmd_i.step)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = swp_q;
      end
      ST_CLRW: ram_we = 1'b1;
      ST_A2: begin
        ram_we    = 1'b1;
        ram_wdata = {newest_q, cnt_new,
                     sum_ok ? wt_new[47:0] : wt_q,
                     sum_ok ? ws_new[31:0] : wsum_q};
      end
      default: ;
    endcase
  end

  cdwc_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.accept),
    .raddr_i(in_addr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    age   = newer_q ? stamp_q - newest_q : newest_q - stamp_q;
    dx    = m_q[38:11];
    dq0   = r_prod_q[51:30];
    drem  = {1'b0, dx} - 29'(dq0) * 29'd125;
    tdiff = pow2_tab({1'b0, y_q[15:12]}) - pow2_tab({1'b0, y_q[15:12]} + 5'd1);
    dv    = tj_q - 17'((ip_q + 24'd2048) >> 12);
    ts    = (66'(phi_q) << 24) + 66'(plo_q) + 66'd32768;
    rem_n = {rem_q[31:0], quo_q[47]};
    rup   = ({rem_q[31:0], 1'b0} > {1'b0, wsum_q}) ||
            (({rem_q[31:0], 1'b0} == {1'b0, wsum_q}) && quo_q[0]);
    qq    = 49'(quo_q) + 49'(rup);
    clo   = (clamp_limit_q >= 15'(ONE_Q14)) ? 17'd0 : 17'(ONE_Q14) - 17'(clamp_limit_q);
    chi   = 17'(ONE_Q14) + 17'(clamp_limit_q);
    cmean = raw_q;
    if (17'(cmean) > chi) cmean = chi[15:0];
    if (17'(cmean) < clo) cmean = clo[15:0];
    vlo  = {ve_low_q, 14'd0};
    vhi  = {ve_high_q, 14'd0};
    plim = pp_q;
    if (plim > 32'(vhi)) plim = 32'(vhi);
    if (plim < 32'(vlo)) plim = 32'(vlo);
    pup  = (plim[13:0] > 14'd8192) || ((plim[13:0] == 14'd8192) && plim[14]);
    pq   = 19'(plim[31:14]) + 19'(pup);
    has  = known_q && (cnt_q >= min_smp_q);
    if (32'(cnt_q) < CONF_LOW) level = 2'd0;
    else if (32'(cnt_q) < CONF_MEDIUM) level = 2'd1;
    else if (32'(cnt_q) < CONF_HIGH) level = 2'd2;
    else level = 2'd3;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= in_user_i;
      addr_ok_q <= in_ok;
      addr_q    <= in_addr;
      corr_q    <= in_data_i[23:8];
      w_q       <= in_data_i[39:24];
      stamp_q   <= in_data_i[71:40];
      pve_q     <= in_data_i[87:72];
      known_q   <= in_data_i[88];
    end
    unique case (cmd_i.step)
      ST_RD: begin
        newer_q <= stamp_q > rd_newest;
        ew_q    <= w_q;
        cnt_q   <= rd_cnt;
        if (rd_cnt == 16'd0) begin
          wsum_q   <= '0;
          wt_q     <= '0;
          newest_q <= stamp_q;
        end else begin
          wsum_q   <= rd_wsum;
          wt_q     <= rd_wt;
          newest_q <= rd_newest;
        end
      end
      ST_D1: p_q <= 48'(age) * 48'(decay_rate_q);
      ST_D2: begin
        big_q <= p_q >= 48'd4096000;
        m_q   <= 39'(p_q[21:0]) * 39'd94548;
      end
      ST_D3: r_prod_q <= 52'(dx) * 52'd8589934;
      ST_D4: y_q <= (drem >= 29'd125) ? 21'(dq0 + 22'd1) : 21'(dq0);
      ST_D5: begin
        n_q  <= y_q[20:16];
        tj_q <= pow2_tab({1'b0, y_q[15:12]});
        ip_q <= 24'(tdiff[11:0]) * 24'(y_q[11:0]);
      end
      ST_D6: f_q <= big_q ? 17'd0 : dv >> n_q;
      ST_S1: begin
        pw_q  <= 49'(wsum_q) * 49'(f_q);
        plo_q <= 41'(wt_q[23:0]) * 41'(f_q);
      end
      ST_S2: phi_q <= 41'(wt_q[47:24]) * 41'(f_q);
      ST_S3: begin
        if (!f_q[16]) begin
          wsum_q <= 32'((pw_q + 49'd32768) >> 16);
          wt_q   <= ts[63:16];
        end
        newest_q <= stamp_q;
      end
      ST_EW: ew_q <= f_q[16] ? w_q : 16'((33'(w_q) * 33'(f_q) + 33'd32768) >> 16);
      ST_A1: ewc_q <= 32'(ew_q) * 32'(corr_q);
      ST_DIVI: begin
        rem_q <= '0;
        quo_q <= wt_q;
      end
      ST_DIV: begin
        if (rem_n >= {1'b0, wsum_q}) begin
          rem_q <= rem_n - {1'b0, wsum_q};
          quo_q <= {quo_q[46:0], 1'b1};
        end else begin
          rem_q <= rem_n;
          quo_q <= {quo_q[46:0], 1'b0};
        end
      end
      ST_R1: raw_q <= (wsum_q == 32'd0) ? ONE_Q14 :
                      (qq > 49'd65535) ? 16'hFFFF : qq[15:0];
      ST_R2: begin
        mean_q    <= clamp_enable_q ? cmean : raw_q;
        clamped_q <= clamp_enable_q && (cmean != raw_q);
      end
      ST_R3: pp_q <= 32'(pve_q) * 32'(mean_q);
      default: ;
    endcase
    if (cmd_i.load_out) begin
      o_cnt_q     <= cnt_q;
      o_mean_q    <= mean_q;
      o_raw_q     <= raw_q;
      o_clamped_q <= clamped_q;
      o_has_q     <= has;
      o_prop_q    <= !has ? 16'd0 : (pq > 19'd65535) ? 16'hFFFF : pq[15:0];
      o_level_q   <= level;
    end
  end

  assign out_data_o = {4'd0, o_level_q, o_prop_q, o_has_q, o_clamped_q,
                       o_raw_q, o_mean_q, o_cnt_q};

endmodule

FILE: rtl/core/cdwc_ctrl.sv
// Controller state machine: handshakes, step sequencing, output slot.
// Depends on cdwc_pkg; drives cdwc_dp through command and status structs.
module cdwc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  input  cdwc_pkg::cdwc_stat_t stat_i,
  output cdwc_pkg::cdwc_cmd_t  cmd_o
);
  import cdwc_pkg::*;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign s_tready_o   = (state_q == ST_IDLE);
  assign m_tvalid_o   = out_valid_q;
  assign cmd_o.step   = state_q;
  assign cmd_o.accept = s_tready_o && s_tvalid_i;
  assign cmd_o.load_out = (state_q == ST_R4) && (!out_valid_q || m_tready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (m_tready_i) out_valid_d = 1'b0;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR:  if (stat_i.sweep_last) state_d = ST_IDLE;
      ST_IDLE: if (cmd_o.accept) state_d = ST_RD;
      ST_RD: begin
        priority if (!stat_i.addr_ok || stat_i.op == OP_NONE) begin
          state_d = ST_IDLE;
        end else if (stat_i.op == OP_CLEAR) begin
          state_d = ST_CLRW;
        end else if (stat_i.op == OP_REPORT) begin
          state_d = ST_DIVI;
        end else if (stat_i.cnt_zero) begin
          state_d = ST_A1;
        end else begin
          state_d = ST_D1;
        end
      end
      ST_CLRW: state_d = ST_IDLE;
      ST_D1:   state_d = ST_D2;
      ST_D2:   state_d = ST_D3;
      ST_D3:   state_d = ST_D4;
      ST_D4:   state_d = ST_D5;
      ST_D5:   state_d = ST_D6;
      ST_D6:   state_d = stat_i.newer ? ST_S1 : ST_EW;
      ST_S1:   state_d = ST_S2;
      ST_S2:   state_d = ST_S3;
      ST_S3:   state_d = ST_A1;
      ST_EW:   state_d = ST_A1;
      ST_A1:   state_d = ST_A2;
      ST_A2:   state_d = ST_IDLE;
      ST_DIVI: state_d = ST_DIV;
      ST_DIV:  if (stat_i.div_last) state_d = ST_R1;
      ST_R1:   state_d = ST_R2;
      ST_R2:   state_d = ST_R3;
      ST_R3:   state_d = ST_R4;
      ST_R4:   if (cmd_o.load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/cell_decayed_weighted_correction.sv
// Top level of the per-cell decayed weighted correction table.
// Depends on cdwc_pkg, cdwc_ctrl, cdwc_dp (with cdwc_ram).
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid/s_tready    tuser op, tdata cell sample
//   m_*       out        m_tvalid/m_tready    tdata report result
//   cfg_*     in         cfg_we               cfg_idx, cfg_data
//
// One item at a time. Clear: read, zeroing write. Add: read, decay and scaling
// steps unless the cell is empty, product, write. Report: read, divider load,
// the one-bit-per-cycle 48-step divider, result steps. After reset a clearing
// pass over all N_ROWS*N_COLS cells zeroes the cell RAM before s_tready rises.
// A pending result may wait in the output register while the next item runs;
// a report finishing into a full output register holds until it drains.
module cell_decayed_weighted_correction #(
  parameter int N_ROWS = cdwc_pkg::DEF_N_ROWS,
  parameter int N_COLS = cdwc_pkg::DEF_N_COLS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // row[3:0] column[7:4] correction[23:8] sample_weight[39:24]
  // stamp_ms[71:40] present_ve[87:72] present_known[88]
  input  logic [cdwc_pkg::IN_DATA_W-1:0]     s_tdata_i,
  // operation[1:0]
  input  logic [cdwc_pkg::IN_USER_W-1:0]     s_tuser_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // count[15:0] mean[31:16] raw[47:32] clamp_hit[48]
  // prop_valid[49] prop_ve[65:50] confidence[67:66]
  output logic [cdwc_pkg::OUT_DATA_W-1:0]    m_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [cdwc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cdwc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import cdwc_pkg::*;

  cdwc_cmd_t  cmd;
  cdwc_stat_t stat;

  cdwc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  cdwc_dp #(
    .N_ROWS(N_ROWS),
    .N_COLS(N_COLS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_data_i (s_tdata_i),
    .in_user_i (s_tuser_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .out_data_o(m_tdata_o)
  );

endmodule

FILE: rtl/core/cdwc_checker.sv
// Port-level checks of the correction table, bound to the top level.
// Depends on cdwc_pkg and cell_decayed_weighted_correction.
module cdwc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_tvalid_i,
  input logic                            s_tready_o,
  input logic                            m_tvalid_o,
  input logic                            m_tready_i,
  input logic [cdwc_pkg::OUT_DATA_W-1:0] m_tdata_o
);
  import cdwc_pkg::*;

  logic [1:0] exp_level;

  always_comb begin
    if (32'(m_tdata_o[15:0]) < CONF_LOW) exp_level = 2'd0;
    else if (32'(m_tdata_o[15:0]) < CONF_MEDIUM) exp_level = 2'd1;
    else if (32'(m_tdata_o[15:0]) < CONF_HIGH) exp_level = 2'd2;
    else exp_level = 2'd3;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("input taken while an item is in work");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tdata_o[67:66] == exp_level)
    else $error("confidence level does not match count");

  a_no_prop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tdata_o[49] |-> m_tdata_o[65:50] == 16'd0)
    else $error("proposed VE without proposal");

  a_unclamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tdata_o[48] |-> m_tdata_o[31:16] == m_tdata_o[47:32])
    else $error("mean differs from raw factor without clamp");

endmodule

bind cell_decayed_weighted_correction cdwc_checker u_cdwc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_tvalid_i(s_tvalid_i),
  .s_tready_o(s_tready_o),
  .m_tvalid_o(m_tvalid_o),
  .m_tready_i(m_tready_i),
  .m_tdata_o (m_tdata_o)
);

FILE: dv/tb_cell_decayed_weighted_correction.sv
// Self-checking testbench for cell_decayed_weighted_correction.
// Drives add, report and clear transactions over the stream ports and checks each report
// against a cycle-free model of the decayed table kept in a small scoreboard class.
// Depends on cdwc_pkg and the RTL of the block.
module tb_cell_decayed_weighted_correction;
  timeunit 1ns;
  timeprecision 1ps;
  import cdwc_pkg::*;

  localparam int CELL_CNT  = DEF_N_ROWS * DEF_N_COLS;
  localparam int MAX_CYC   = 3000000;
  localparam int DRAIN_CYC = 120;

  typedef struct packed {
    logic [15:0] count;
    logic [15:0] mean;
    logic [15:0] raw;
    logic        clamped;
    logic        has_prop;
    logic [15:0] prop;
    logic [1:0]  level;
  } report_t;

  class decay_table_sb;
    bit [31:0] weight_acc [CELL_CNT];
    bit [47:0] corr_acc [CELL_CNT];
    bit [15:0] sample_cnt [CELL_CNT];
    bit [31:0] last_stamp [CELL_CNT];
    bit [15:0] min_smp, decay_rate, ve_low, ve_high;
    bit        clamp_en;
    bit [14:0] clamp_lim;
    report_t   reports_due [$];
    int        errors;
    bit [16:0] exp2_tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                                 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                                 32768};

    function new();
      min_smp     = 16'd3;
      decay_rate  = 16'd0;
      clamp_en    = 1'b0;
      clamp_lim   = 15'd0;
      ve_low      = 16'd0;
      ve_high     = 16'hFFFF;
      errors      = 0;
      foreach (weight_acc[i]) begin
        weight_acc[i] = '0;
        corr_acc[i]   = '0;
        sample_cnt[i] = '0;
        last_stamp[i] = '0;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_MIN_SMP:      min_smp     = data;
        REG_DECAY_RATE:   decay_rate  = data;
        REG_CLAMP_ENABLE: clamp_en    = data[0];
        REG_CLAMP_LIMIT:  clamp_lim   = data[14:0];
        REG_VE_LOW:       ve_low      = data;
        REG_VE_HIGH:      ve_high     = data;
        default: ;
      endcase
    endfunction

    function bit [63:0] age_factor(bit [31:0] age_ms);
      bit [63:0] p, y, v;
      bit [63:0] n, j, t;
      p = 64'(age_ms) * 64'(decay_rate);
      if (p >= 64'd4096000) return 0;
      y = (p * 64'd94548) / 64'd256000;
      n = y >> 16;
      j = (y & 64'hFFFF) >> 12;
      t = y & 64'hFFF;
      v = exp2_tab[j] - (((exp2_tab[j] - exp2_tab[j + 1]) * t + 64'd2048) >> 12);
      if (n >= 32) return 0;
      return v >> n;
    endfunction

    function bit [63:0] scale_by(bit [63:0] s, bit [63:0] f);
      if (f >= 64'd65536) return s;
      return (s * f + 64'd32768) >> 16;
    endfunction

    function bit [63:0] div_even(bit [63:0] num, bit [63:0] den);
      bit [63:0] q, r;
      q = num / den;
      r = num % den;
      if (2 * r > den || (2 * r == den && q[0])) q++;
      return q;
    endfunction

    function void note_item(logic [1:0] op, logic [88:0] d);
      int        c;
      bit [63:0] ew, ws, wt, f, q, p, lo, hi;
      bit [31:0] stamp;
      bit [15:0] corr, lo_b;
      bit [16:0] hi_b;
      report_t   r;
      c     = int'(d[3:0]) * DEF_N_COLS + int'(d[7:4]);
      corr  = d[23:8];
      ew    = 64'(d[39:24]);
      stamp = d[71:40];
      case (op)
        OP_ADD: begin
          if (sample_cnt[c] == 0) begin
            weight_acc[c] = '0;
            corr_acc[c]   = '0;
            last_stamp[c] = stamp;
          end else if (stamp > last_stamp[c]) begin
            f = age_factor(stamp - last_stamp[c]);
            weight_acc[c] = 32'(scale_by(64'(weight_acc[c]), f));
            corr_acc[c]   = 48'(scale_by(64'(corr_acc[c]), f));
            last_stamp[c] = stamp;
          end else begin
            ew = scale_by(ew, age_factor(last_stamp[c] - stamp));
          end
          ws = 64'(weight_acc[c]) + ew;
          wt = 64'(corr_acc[c]) + ew * 64'(corr);
          if (ws <= 64'hFFFF_FFFF && wt <= 64'hFFFF_FFFF_FFFF) begin
            weight_acc[c] = 32'(ws);
            corr_acc[c]   = 48'(wt);
          end
          if (sample_cnt[c] != 16'hFFFF) sample_cnt[c]++;
        end
        OP_CLEAR: begin
          weight_acc[c] = '0;
          corr_acc[c]   = '0;
          sample_cnt[c] = '0;
          last_stamp[c] = '0;
        end
        OP_REPORT: begin
          r = '0;
          r.count = sample_cnt[c];
          r.raw   = ONE_Q14;
          if (weight_acc[c] != 0) begin
            q = div_even(64'(corr_acc[c]), 64'(weight_acc[c]));
            r.raw = (q > 64'd65535) ? 16'hFFFF : 16'(q);
          end
          r.mean = r.raw;
          if (clamp_en) begin
            lo_b = (clamp_lim >= 15'(ONE_Q14)) ? 16'd0 : ONE_Q14 - 16'(clamp_lim);
            hi_b = 17'(ONE_Q14) + 17'(clamp_lim);
            if (17'(r.mean) > hi_b) r.mean = 16'(hi_b);
            if (r.mean < lo_b) r.mean = lo_b;
            r.clamped = (r.mean != r.raw);
          end
          if (d[88] && r.count >= min_smp) begin
            p  = 64'(d[87:72]) * 64'(r.mean);
            lo = 64'(ve_low) << 14;
            hi = 64'(ve_high) << 14;
            if (p > hi) p = hi;
            if (p < lo) p = lo;
            q = div_even(p, 64'(ONE_Q14));
            r.prop     = (q > 64'd65535) ? 16'hFFFF : 16'(q);
            r.has_prop = 1'b1;
          end
          if (r.count < CONF_LOW) r.level = 2'd0;
          else if (r.count < CONF_MEDIUM) r.level = 2'd1;
          else if (r.count < CONF_HIGH) r.level = 2'd2;
          else r.level = 2'd3;
          reports_due = {reports_due, r};
        end
        default: ;
      endcase
    endfunction

    function void field_cmp(string name, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
        $display("%0t ns: %s expected %0d actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_report(logic [OUT_DATA_W-1:0] d);
      report_t e;
      if (reports_due.size() == 0) begin
        $display("%0t ns: unexpected report expected none actual %h", $time, d);
        errors++;
        return;
      end
      e = reports_due.pop_front();
      field_cmp("count", e.count, d[15:0]);
      field_cmp("mean", e.mean, d[31:16]);
      field_cmp("raw", e.raw, d[47:32]);
      field_cmp("clamp_hit", 16'(e.clamped), 16'(d[48]));
      field_cmp("prop_valid", 16'(e.has_prop), 16'(d[49]));
      field_cmp("prop_ve", e.prop, d[65:50]);
      field_cmp("confidence", 16'(e.level), 16'(d[67:66]));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid_i = 1'b0;
  logic                  s_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata_i = '0;
  logic [IN_USER_W-1:0]  s_tuser_i = '0;
  logic                  m_tvalid_o;
  logic                  m_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  decay_table_sb sb = new();
  int            cycles = 0;
  bit            long_hold = 1'b0;
  bit            burst = 1'b0;
  bit [31:0]     now_ms = 32'd1000;
  int            hot_cell [4];

  always #5 clk_i = ~clk_i;

  cell_decayed_weighted_correction DUT (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tdata_i, .s_tuser_i,
    .m_tvalid_o, .m_tready_i, .m_tdata_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("cell_decayed_weighted_correction: mismatch");
      $finish;
    end
  end

  initial begin
    int stall;
    forever begin
      stall = long_hold ? 400 : ((($urandom_range(0, 3) == 0)) ? 0 : $urandom_range(0, 18));
      long_hold = 1'b0;
      @(negedge clk_i);
      m_tready_i = 1'b0;
      repeat (stall) @(negedge clk_i);
      m_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      sb.check_report(m_tdata_o);
    end
  end

  task automatic send_item(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                           logic [15:0] corr, logic [15:0] w, logic [31:0] stamp,
                           logic [15:0] pve, logic known);
    int gap;
    gap = (burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tuser_i  = op;
    s_tdata_i  = {7'd0, known, pve, stamp, w, corr, col, row};
    s_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_item(op, s_tdata_i[88:0]);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_tvalid_i = 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_idx_i  = idx;
    cfg_data_i = data;
    cfg_we_i   = 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_item();
    logic [1:0]  op;
    logic [3:0]  row, col;
    logic [31:0] stamp;
    int          k, c;
    k  = $urandom_range(0, 99);
    op = (k < 55) ? OP_ADD : (k < 88) ? OP_REPORT : (k < 95) ? OP_CLEAR : OP_NONE;
    c  = ($urandom_range(0, 4) != 0) ? hot_cell[$urandom_range(0, 3)] : $urandom_range(0, 255);
    row = 4'(c / DEF_N_COLS);
    col = 4'(c % DEF_N_COLS);
    if ($urandom_range(0, 9) == 0) begin
      stamp = now_ms - $urandom_range(0, 20000);
    end else begin
      now_ms += $urandom_range(0, 3000);
      stamp = now_ms;
    end
    send_item(op, row, col, 16'($urandom_range(8000, 30000) ^ ($urandom_range(0, 9) == 0 ?
              $urandom() : 0)), 16'($urandom()), stamp, 16'($urandom()),
              logic'($urandom_range(0, 3) != 0));
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      hot_cell[i % 4] = (i % 97 == 0) ? $urandom_range(0, 255) : hot_cell[i % 4];
      random_item();
    end
    settle();
  endtask

  initial begin
    foreach (hot_cell[i]) hot_cell[i] = $urandom_range(0, 255);
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    while (!s_tready_o) @(negedge clk_i);

    // directed: empty cells, field extremes, older stamps, clear, unused op
    send_item(OP_REPORT, 4'd15, 4'd15, 16'd0, 16'd0, 32'd0, 16'hFFFF, 1'b1);
    send_item(OP_ADD, 4'd0, 4'd0, 16'd0, 16'd0, 32'd0, 16'd0, 1'b0);
    send_item(OP_REPORT, 4'd0, 4'd0, 16'd0, 16'd0, 32'd0, 16'hFFFF, 1'b1);
    send_item(OP_ADD, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 1'b0);
    send_item(OP_ADD, 4'd0, 4'd0, 16'h4000, 16'd1, 32'd5, 16'd0, 1'b0);
    send_item(OP_REPORT, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_item(OP_ADD, 4'd15, 4'd15, 16'h4000, 16'h8000, 32'd100, 16'd0, 1'b0);
    send_item(OP_ADD, 4'd15, 4'd15, 16'h6000, 16'h8000, 32'd50, 16'd0, 1'b0);
    send_item(OP_ADD, 4'd15, 4'd15, 16'h2000, 16'h7FFF, 32'd900, 16'd0, 1'b0);
    send_item(OP_REPORT, 4'd15, 4'd15, 16'd0, 16'd0, 32'd0, 16'd12345, 1'b1);
    send_item(OP_REPORT, 4'd15, 4'd15, 16'd0, 16'd0, 32'd0, 16'd12345, 1'b0);
    send_item(OP_NONE, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_item(OP_CLEAR, 4'd0, 4'd0, 16'd0, 16'd0, 32'd0, 16'd0, 1'b0);
    send_item(OP_REPORT, 4'd0, 4'd0, 16'd0, 16'd0, 32'd0, 16'd100, 1'b1);
    send_item(OP_REPORT, 4'd15, 4'd15, 16'd0, 16'd0, 32'd0, 16'hFFFF, 1'b1);
    settle();

    random_phase(350);

    // extremes: no sample floor, fastest decay, tight clamp, crossed VE limits
    write_reg(REG_MIN_SMP, 16'd0);
    write_reg(REG_DECAY_RATE, 16'hFFFF);
    write_reg(REG_CLAMP_ENABLE, 16'd1);
    write_reg(REG_CLAMP_LIMIT, 16'd0);
    write_reg(REG_VE_LOW, 16'hFFFF);
    write_reg(REG_VE_HIGH, 16'd0);
    write_reg(3'd6, 16'hFFFF);
    write_reg(3'd7, 16'd1);
    random_phase(300);

    write_reg(REG_MIN_SMP, 16'hFFFF);
    write_reg(REG_DECAY_RATE, 16'd256);
    write_reg(REG_CLAMP_LIMIT, 16'h7FFF);
    write_reg(REG_VE_LOW, 16'd0);
    write_reg(REG_VE_HIGH, 16'hFFFF);
    random_phase(300);

    write_reg(REG_MIN_SMP, 16'd2);
    write_reg(REG_DECAY_RATE, 16'd32);
    write_reg(REG_CLAMP_LIMIT, 16'd16384);
    write_reg(REG_VE_LOW, 16'd5000);
    write_reg(REG_VE_HIGH, 16'd15000);
    long_hold = 1'b1;
    burst     = 1'b1;
    for (int i = 0; i < 40; i++)
      send_item(OP_REPORT, 4'($urandom()), 4'($urandom()), 16'd0, 16'd0, 32'd0,
                16'($urandom()), 1'b1);
    burst = 1'b0;
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_MIN_SMP, 16'($urandom_range(0, 40)));
      write_reg(REG_DECAY_RATE, 16'($urandom_range(0, 600)));
      write_reg(REG_CLAMP_ENABLE, 16'($urandom_range(0, 1)));
      write_reg(REG_CLAMP_LIMIT, 16'($urandom_range(0, 16384)));
      write_reg(REG_VE_LOW, 16'($urandom_range(0, 8000)));
      write_reg(REG_VE_HIGH, 16'($urandom_range(6000, 65535)));
      random_phase(315);
    end

    if (sb.errors == 0 && sb.reports_due.size() == 0) begin
      $display("cell_decayed_weighted_correction: match");
    end else begin
      $display("cell_decayed_weighted_correction: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/cdwc_pkg.sv
rtl/core/cdwc_ram.sv
rtl/core/cdwc_dp.sv
rtl/core/cdwc_ctrl.sv
rtl/core/cell_decayed_weighted_correction.sv
rtl/core/cdwc_checker.sv
dv/tb_cell_decayed_weighted_correction.sv
